// File: sv/iwec_pkg.sv
package iwec_pkg;

   localparam int COEF_W      = 32;
   localparam int ACC_W       = 40;
   localparam int WEIGHT_W    = 32;
   localparam int OFF_W       = 4;
   localparam int IDX_W       = 5;
   localparam int CUT_W       = 6;
   localparam int FRAC_SHIFT  = 24;
   localparam int MAX_STENCIL = 27;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_ENTRY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_ENTRY  = 2'd3;

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic signed [OFF_W-1:0]  offset_along_dir;
      logic [IDX_W-1:0]         entry_index;
      logic                     last_entry;
   } req_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight_lower;
      logic signed [WEIGHT_W-1:0] weight_upper;
      logic                       center_was_zero;
   } rsp_type;

   typedef struct packed {
      logic [ACC_W-1:0] center_sum;
      logic [ACC_W-1:0] lower_sum;
      logic [ACC_W-1:0] upper_sum;
      logic             lower_cut;
      logic             upper_cut;
   } point_type;

endpackage

// File: sv/interp_weights_with_edge_cut_core.sv
// Interpolation weights with edge cut.
// The req channel carries one stencil coefficient per transaction together
// with its offset along the coarsening direction, its entry index and a
// last-entry mark. Each coefficient is accumulated as it is accepted, so a point
// streams in at one transaction per clock, except that its last transaction
// stalls while the divider is busy. That transaction closes the point and hands
// its sums to a bit-serial divider that produces one quotient bit per cycle for
// both weights in parallel. The rsp channel carries both Q8.24 weights and the
// zero-center flag. After the last transaction is accepted, the divider captures
// the point, runs the set-up states ST_ABS and ST_CMP, 32 divider steps in ST_RUN
// and the formatting state ST_FIN, which waits while an earlier result is held.
// While the divider is busy, coefficients of the next point are still accepted;
// only its last transaction is stalled until the divider is free again.
// The result holds steady while rsp_stall is high. Reset restores the register
// defaults and clears the accumulated sums and cut flags; in the divider only
// the state and rsp_valid are reset. The csr port writes the offset and
// cut-entry registers, to be done while idle only; the block does not enforce it.
module interp_weights_with_edge_cut_core
   import iwec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic      div_busy;
   logic      div_start;
   point_type div_point;

   iwec_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .div_busy    (div_busy),
      .div_start   (div_start),
      .div_point   (div_point)
   );

   iwec_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .point     (div_point),
      .busy      (div_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/iwec_acc.sv
module iwec_acc
   import iwec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  div_busy,
   output logic                  div_start,
   output point_type             div_point
);

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_STENCIL);

   logic [OFF_W-1:0] lower_offset_ff, lower_offset_in;
   logic [OFF_W-1:0] upper_offset_ff, upper_offset_in;
   logic [CUT_W-1:0] lower_entry_ff, lower_entry_in;
   logic [CUT_W-1:0] upper_entry_ff, upper_entry_in;

   logic [ACC_W-1:0] center_sum_ff, center_sum_in;
   logic [ACC_W-1:0] lower_sum_ff, lower_sum_in;
   logic [ACC_W-1:0] upper_sum_ff, upper_sum_in;
   logic             lower_cut_ff, lower_cut_in;
   logic             upper_cut_ff, upper_cut_in;

   logic             accept;
   logic             in_range;
   logic             hit_center, hit_lower, hit_upper;
   logic [ACC_W-1:0] coef_ext, operand, base_sum, sat_sum;
   logic [ACC_W:0]   raw_sum;
   logic             coef_zero;
   point_type        next_point;

   assign req_stall = req_data.last_entry & div_busy;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      lower_offset_in = lower_offset_ff;
      upper_offset_in = upper_offset_ff;
      lower_entry_in  = lower_entry_ff;
      upper_entry_in  = upper_entry_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LOWER_OFFSET: lower_offset_in = csr_wr_data[OFF_W-1:0];
            CSR_UPPER_OFFSET: upper_offset_in = csr_wr_data[OFF_W-1:0];
            CSR_LOWER_ENTRY:  lower_entry_in  = csr_wr_data[CUT_W-1:0];
            CSR_UPPER_ENTRY:  upper_entry_in  = csr_wr_data[CUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_range   = req_data.entry_index < IDX_LIMIT;
      hit_center = req_data.offset_along_dir == '0;
      hit_lower  = ~hit_center && (req_data.offset_along_dir == lower_offset_ff);
      hit_upper  = ~hit_center && ~hit_lower &&
                   (req_data.offset_along_dir == upper_offset_ff);
      coef_ext   = {{(ACC_W-COEF_W){req_data.coefficient[COEF_W-1]}},
                    req_data.coefficient};
      coef_zero  = req_data.coefficient == '0;
      operand    = hit_center ? coef_ext : (ACC_W'(0) - coef_ext);
      if (hit_center) begin
         base_sum = center_sum_ff;
      end else if (hit_lower) begin
         base_sum = lower_sum_ff;
      end else begin
         base_sum = upper_sum_ff;
      end
      raw_sum = {base_sum[ACC_W-1], base_sum} + {operand[ACC_W-1], operand};
      if (raw_sum[ACC_W] != raw_sum[ACC_W-1]) begin
         sat_sum = raw_sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_sum = raw_sum[ACC_W-1:0];
      end

      next_point.center_sum = center_sum_ff;
      next_point.lower_sum  = lower_sum_ff;
      next_point.upper_sum  = upper_sum_ff;
      next_point.lower_cut  = lower_cut_ff;
      next_point.upper_cut  = upper_cut_ff;
      if (in_range) begin
         if (hit_center) begin
            next_point.center_sum = sat_sum;
         end
         if (hit_lower) begin
            next_point.lower_sum = sat_sum;
         end
         if (hit_upper) begin
            next_point.upper_sum = sat_sum;
         end
         if (coef_zero && ({1'b0, req_data.entry_index} == lower_entry_ff)) begin
            next_point.lower_cut = 1'b1;
         end
         if (coef_zero && ({1'b0, req_data.entry_index} == upper_entry_ff)) begin
            next_point.upper_cut = 1'b1;
         end
      end

      div_point = next_point;
      div_start = accept & req_data.last_entry;

      center_sum_in = center_sum_ff;
      lower_sum_in  = lower_sum_ff;
      upper_sum_in  = upper_sum_ff;
      lower_cut_in  = lower_cut_ff;
      upper_cut_in  = upper_cut_ff;
      if (accept) begin
         if (req_data.last_entry) begin
            center_sum_in = '0;
            lower_sum_in  = '0;
            upper_sum_in  = '0;
            lower_cut_in  = 1'b0;
            upper_cut_in  = 1'b0;
         end else begin
            center_sum_in = next_point.center_sum;
            lower_sum_in  = next_point.lower_sum;
            upper_sum_in  = next_point.upper_sum;
            lower_cut_in  = next_point.lower_cut;
            upper_cut_in  = next_point.upper_cut;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_offset_ff <= OFF_W'(-1);
         upper_offset_ff <= OFF_W'(1);
         lower_entry_ff  <= CUT_W'(-1);
         upper_entry_ff  <= CUT_W'(-1);
         center_sum_ff   <= '0;
         lower_sum_ff    <= '0;
         upper_sum_ff    <= '0;
         lower_cut_ff    <= 1'b0;
         upper_cut_ff    <= 1'b0;
      end else begin
         lower_offset_ff <= lower_offset_in;
         upper_offset_ff <= upper_offset_in;
         lower_entry_ff  <= lower_entry_in;
         upper_entry_ff  <= upper_entry_in;
         center_sum_ff   <= center_sum_in;
         lower_sum_ff    <= lower_sum_in;
         upper_sum_ff    <= upper_sum_in;
         lower_cut_ff    <= lower_cut_in;
         upper_cut_ff    <= upper_cut_in;
      end
   end

endmodule

// File: sv/iwec_div.sv
module iwec_div
   import iwec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  point_type point,
   output logic      busy,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ABS  = 5'b00010,
      ST_CMP  = 5'b00100,
      ST_RUN  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   localparam int Q_W   = WEIGHT_W;
   localparam int CNT_W = $clog2(Q_W);
   localparam int LOW_W = Q_W - FRAC_SHIFT;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);
   localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   point_type        pt_ff, pt_in;
   logic [ACC_W-1:0] den_ff, den_in;
   logic [ACC_W-1:0] num_l_ff, num_l_in, num_u_ff, num_u_in;
   logic [ACC_W-1:0] rem_l_ff, rem_l_in, rem_u_ff, rem_u_in;
   logic [LOW_W-1:0] dvd_l_ff, dvd_l_in, dvd_u_ff, dvd_u_in;
   logic [Q_W-1:0]   q_l_ff, q_l_in, q_u_ff, q_u_in;
   logic             neg_l_ff, neg_l_in, neg_u_ff, neg_u_in;
   logic             ovf_l_ff, ovf_l_in, ovf_u_ff, ovf_u_in;
   logic             zero_ff, zero_in;
   rsp_type          rsp_ff, rsp_in;
   logic             out_valid_ff, out_valid_in;
   logic [ACC_W:0]   step_l, step_u;

   function automatic logic [ACC_W-1:0] abs_val(input logic [ACC_W-1:0] v);
      return v[ACC_W-1] ? (ACC_W'(0) - v) : v;
   endfunction

   function automatic logic [ACC_W:0] div_step(input logic [ACC_W-1:0] rem,
                                                input logic             din,
                                                input logic [ACC_W-1:0] den);
      logic [ACC_W:0]   trial;
      logic [ACC_W+1:0] diff;
      trial = {rem, din};
      diff  = {1'b0, trial} - {2'b00, den};
      if (!diff[ACC_W+1]) begin
         return {1'b1, diff[ACC_W-1:0]};
      end
      return {1'b0, trial[ACC_W-1:0]};
   endfunction

   function automatic logic [Q_W-1:0] sat_weight(input logic [Q_W-1:0] q,
                                                 input logic           ovf,
                                                 input logic           neg);
      if (neg) begin
         if (ovf || (q > NEG_MAX)) begin
            return NEG_MAX;
         end
         return Q_W'(0) - q;
      end
      if (ovf || q[Q_W-1]) begin
         return POS_MAX;
      end
      return q;
   endfunction

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pt_in        = pt_ff;
      den_in       = den_ff;
      num_l_in     = num_l_ff;
      num_u_in     = num_u_ff;
      rem_l_in     = rem_l_ff;
      rem_u_in     = rem_u_ff;
      dvd_l_in     = dvd_l_ff;
      dvd_u_in     = dvd_u_ff;
      q_l_in       = q_l_ff;
      q_u_in       = q_u_ff;
      neg_l_in     = neg_l_ff;
      neg_u_in     = neg_u_ff;
      ovf_l_in     = ovf_l_ff;
      ovf_u_in     = ovf_u_ff;
      zero_in      = zero_ff;
      rsp_in       = rsp_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      step_l   = div_step(rem_l_ff, dvd_l_ff[LOW_W-1], den_ff);
      step_u   = div_step(rem_u_ff, dvd_u_ff[LOW_W-1], den_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pt_in    = point;
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            den_in   = abs_val(pt_ff.center_sum);
            num_l_in = abs_val(pt_ff.lower_sum);
            num_u_in = abs_val(pt_ff.upper_sum);
            neg_l_in = pt_ff.lower_sum[ACC_W-1] ^ pt_ff.center_sum[ACC_W-1];
            neg_u_in = pt_ff.upper_sum[ACC_W-1] ^ pt_ff.center_sum[ACC_W-1];
            zero_in  = pt_ff.center_sum == '0;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            ovf_l_in = {{LOW_W{1'b0}}, num_l_ff} >= {den_ff, {LOW_W{1'b0}}};
            ovf_u_in = {{LOW_W{1'b0}}, num_u_ff} >= {den_ff, {LOW_W{1'b0}}};
            rem_l_in = {{LOW_W{1'b0}}, num_l_ff[ACC_W-1:LOW_W]};
            rem_u_in = {{LOW_W{1'b0}}, num_u_ff[ACC_W-1:LOW_W]};
            dvd_l_in = num_l_ff[LOW_W-1:0];
            dvd_u_in = num_u_ff[LOW_W-1:0];
            cnt_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rem_l_in = step_l[ACC_W-1:0];
            rem_u_in = step_u[ACC_W-1:0];
            q_l_in   = {q_l_ff[Q_W-2:0], step_l[ACC_W]};
            q_u_in   = {q_u_ff[Q_W-2:0], step_u[ACC_W]};
            dvd_l_in = {dvd_l_ff[LOW_W-2:0], 1'b0};
            dvd_u_in = {dvd_u_ff[LOW_W-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!out_valid_ff || !rsp_stall) begin
               rsp_in.weight_lower    = sat_weight(q_l_ff, ovf_l_ff, neg_l_ff);
               rsp_in.weight_upper    = sat_weight(q_u_ff, ovf_u_ff, neg_u_ff);
               rsp_in.center_was_zero = zero_ff;
               if (zero_ff || pt_ff.lower_cut) begin
                  rsp_in.weight_lower = '0;
               end
               if (zero_ff || pt_ff.upper_cut) begin
                  rsp_in.weight_upper = '0;
               end
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff   <= cnt_in;
      pt_ff    <= pt_in;
      den_ff   <= den_in;
      num_l_ff <= num_l_in;
      num_u_ff <= num_u_in;
      rem_l_ff <= rem_l_in;
      rem_u_ff <= rem_u_in;
      dvd_l_ff <= dvd_l_in;
      dvd_u_ff <= dvd_u_in;
      q_l_ff   <= q_l_in;
      q_u_ff   <= q_u_in;
      neg_l_ff <= neg_l_in;
      neg_u_ff <= neg_u_in;
      ovf_l_ff <= ovf_l_in;
      ovf_u_ff <= ovf_u_in;
      zero_ff  <= zero_in;
      rsp_ff   <= rsp_in;
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("divider started while busy");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !zero_ff && !ovf_l_ff |-> rem_l_ff < den_ff)
      else $error("lower remainder not below divisor");

   a_zero_center: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.center_was_zero |->
         (rsp_data.weight_lower == '0) && (rsp_data.weight_upper == '0))
      else $error("zero center with nonzero weight");

   a_out_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FIN))
      else $error("result raised without final step");

endmodule
